FILE: sv/token_bucket_rate_limiter_top_macros.svh
// Assertion macros for the token bucket rate limiter.
// Included by the checker; no other dependencies.
`ifndef TOKEN_BUCKET_RATE_LIMITER_TOP_MACROS_SVH
`define TOKEN_BUCKET_RATE_LIMITER_TOP_MACROS_SVH

// checked only while out of reset
`define TBRL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define TBRL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tbrl_pkg.sv
// Shared types and constants of the token bucket rate limiter.
// No dependencies; used by controller, datapath and top level.
`default_nettype none

package tbrl_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 24;
  localparam int unsigned BURST_BITS_DEF    = 16;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned TOKEN_W   = 16;
  localparam int unsigned ELAPSED_W = 24;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned WAIT_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_REFILL_PER_US = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BURST     = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_REFILL  = 3'd0,
    OP_TAKE    = 3'd1,
    OP_CONSUME = 3'd2,
    OP_WAIT    = 3'd3,
    OP_RESTART = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/token_bucket_rate_limiter_top.sv
// Flow: an accepted word is loaded, then prepared; a wait query that is short of
// tokens with a nonzero rate then runs the restoring divider, one quotient bit a
// cycle. The result is then committed to the output register once that is free.
// One word is in flight at a time: a new word is taken only after the last result
// is committed, but a new word is taken while a result waits. Reset (async, active low): level one
// whole token, refill rate 0, max burst 1.
`default_nettype none

module token_bucket_rate_limiter_top #(
  parameter int unsigned FRACTION_BITS = tbrl_pkg::FRACTION_BITS_DEF,
  parameter int unsigned BURST_BITS    = tbrl_pkg::BURST_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [tbrl_pkg::OP_W-1:0]       operation_i,
  input  wire logic [tbrl_pkg::TOKEN_W-1:0]    token_count_i,
  input  wire logic [tbrl_pkg::ELAPSED_W-1:0]  elapsed_us_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 granted_o,
  output logic [tbrl_pkg::TOKEN_W-1:0]         available_o,
  output logic [tbrl_pkg::WAIT_W-1:0]          wait_us_o,
  output logic                                 wait_unbounded_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tbrl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tbrl_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  tbrl_pkg::cmd_t    cmd;
  tbrl_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  tbrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tbrl_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .BURST_BITS    (BURST_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .token_count_i    (token_count_i),
    .elapsed_us_i     (elapsed_us_i),
    .granted_o        (granted_o),
    .available_o      (available_o),
    .wait_us_o        (wait_us_o),
    .wait_unbounded_o (wait_unbounded_o)
  );

endmodule

`default_nettype wire

FILE: sv/tbrl_ctrl.sv
// Controller state machine of the token bucket rate limiter.
// Depends on tbrl_pkg; drives the datapath through cmd_t, reads status_t.
`default_nettype none

module tbrl_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire tbrl_pkg::status_t status_i,
  output tbrl_pkg::cmd_t         cmd_o
);

  tbrl_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbrl_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      tbrl_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tbrl_pkg::S_PREP;
        end
      end
      tbrl_pkg::S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = status_i.need_div ? tbrl_pkg::S_DIV : tbrl_pkg::S_DONE;
      end
      tbrl_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = tbrl_pkg::S_DONE;
        end
      end
      tbrl_pkg::S_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = tbrl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tbrl_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: sv/tbrl_datapath.sv
// Datapath of the token bucket rate limiter: level, config registers,
// refill multiplier, restoring divider and output register. Uses tbrl_pkg.
`default_nettype none

module tbrl_datapath #(
  parameter int unsigned FRACTION_BITS = tbrl_pkg::FRACTION_BITS_DEF,
  parameter int unsigned BURST_BITS    = tbrl_pkg::BURST_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire tbrl_pkg::cmd_t                     cmd_i,
  output tbrl_pkg::status_t                       status_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [tbrl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [tbrl_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  input  wire logic [tbrl_pkg::OP_W-1:0]          operation_i,
  input  wire logic [tbrl_pkg::TOKEN_W-1:0]       token_count_i,
  input  wire logic [tbrl_pkg::ELAPSED_W-1:0]     elapsed_us_i,
  output logic                                    granted_o,
  output logic [tbrl_pkg::TOKEN_W-1:0]            available_o,
  output logic [tbrl_pkg::WAIT_W-1:0]             wait_us_o,
  output logic                                    wait_unbounded_o
);

  localparam int unsigned LW   = BURST_BITS + FRACTION_BITS;
  localparam int unsigned NW   = tbrl_pkg::TOKEN_W + FRACTION_BITS;
  localparam int unsigned CW   = (LW > NW) ? LW : NW;
  localparam int unsigned PW   = tbrl_pkg::ELAPSED_W + tbrl_pkg::RATE_W;
  localparam int unsigned SW   = ((LW > PW) ? LW : PW) + 1;
  localparam int unsigned CNTW = $clog2(NW + 1);
  localparam int unsigned RW   = tbrl_pkg::RATE_W;

  localparam logic [LW-1:0] ONE_TOKEN = LW'(1) << FRACTION_BITS;
  localparam logic [32:0]   BURST_LIM = (33'd1 << BURST_BITS) - 33'd1;

  logic [RW-1:0]                   rate_q;
  logic [tbrl_pkg::TOKEN_W-1:0]    burst_q;
  logic [LW-1:0]                   level_q;
  tbrl_pkg::op_e                   op_q;
  logic [tbrl_pkg::TOKEN_W-1:0]    n_q;
  logic [tbrl_pkg::ELAPSED_W-1:0]  el_q;
  logic [PW-1:0]                   prod_q;
  logic                            short_q;
  logic [NW-1:0]                   quot_q;
  logic [RW-1:0]                   rem_q;
  logic [CNTW-1:0]                 cnt_q;
  logic                            granted_q;
  logic [tbrl_pkg::TOKEN_W-1:0]    avail_q;
  logic [tbrl_pkg::WAIT_W-1:0]     wait_q;
  logic                            unb_q;

  logic [32:0]    mb_sat;
  logic [LW-1:0]  cap;
  logic [NW-1:0]  need;
  logic [CW-1:0]  need_c, lvl_c;
  logic           need_gt;
  logic [NW-1:0]  deficit;
  logic [SW-1:0]  sum;
  logic [RW:0]    rem_sh;
  logic           q_bit;
  logic [NW:0]    q_ceil;
  logic [LW-1:0]  level_d;
  logic           granted_d;
  logic [tbrl_pkg::WAIT_W-1:0] wait_d;
  logic           unb_d;

  // burst limit: zero counts as one, saturate at the level's integer range
  always_comb begin
    mb_sat = 33'(burst_q);
    if (mb_sat == 33'd0) begin
      mb_sat = 33'd1;
    end
    if (mb_sat > BURST_LIM) begin
      mb_sat = BURST_LIM;
    end
  end

  assign cap     = {mb_sat[BURST_BITS-1:0], {FRACTION_BITS{1'b0}}};
  assign need    = {n_q, {FRACTION_BITS{1'b0}}};
  assign need_c  = CW'(need);
  assign lvl_c   = CW'(level_q);
  assign need_gt = need_c > lvl_c;
  assign deficit = NW'(need_c - lvl_c);
  assign sum     = SW'(level_q) + SW'(prod_q);

  // one restoring step per cycle
  assign rem_sh = {rem_q, quot_q[NW-1]};
  assign q_bit  = rem_sh >= {1'b0, rate_q};

  assign q_ceil = {1'b0, quot_q} + (NW+1)'(rem_q != '0);

  assign status_o.need_div = (op_q == tbrl_pkg::OP_WAIT) && need_gt && (rate_q != '0);
  assign status_o.div_last = cnt_q == CNTW'(1);

  always_comb begin
    level_d   = level_q;
    granted_d = 1'b0;
    wait_d    = '0;
    unb_d     = 1'b0;
    case (op_q)
      tbrl_pkg::OP_REFILL: begin
        level_d = (sum > SW'(cap)) ? cap : LW'(sum);
      end
      tbrl_pkg::OP_TAKE: begin
        if (level_q >= ONE_TOKEN) begin
          level_d   = level_q - ONE_TOKEN;
          granted_d = 1'b1;
        end
      end
      tbrl_pkg::OP_CONSUME: begin
        level_d = need_gt ? '0 : LW'(lvl_c - need_c);
      end
      tbrl_pkg::OP_WAIT: begin
        if (short_q) begin
          if (rate_q == '0) begin
            unb_d  = 1'b1;
            wait_d = '1;
          end else if ((q_ceil >> tbrl_pkg::WAIT_W) != '0) begin
            wait_d = '1;
          end else begin
            wait_d = tbrl_pkg::WAIT_W'(q_ceil);
          end
        end
      end
      tbrl_pkg::OP_RESTART: begin
        level_d = cap;
      end
      default: begin
        level_d = level_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= '0;
      burst_q <= tbrl_pkg::TOKEN_W'(1);
      level_q <= ONE_TOKEN;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tbrl_pkg::REG_REFILL_PER_US: rate_q  <= cfg_data_i;
          tbrl_pkg::REG_MAX_BURST:     burst_q <= cfg_data_i[tbrl_pkg::TOKEN_W-1:0];
          default: begin
            // drop writes outside the register list
          end
        endcase
      end
      if (cmd_i.commit) begin
        level_q <= level_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= tbrl_pkg::op_e'(operation_i);
      n_q  <= token_count_i;
      el_q <= elapsed_us_i;
    end
    if (cmd_i.prep) begin
      prod_q  <= PW'(el_q) * PW'(rate_q);
      short_q <= need_gt;
      quot_q  <= deficit;
      rem_q   <= '0;
      cnt_q   <= CNTW'(NW);
    end
    if (cmd_i.div_step) begin
      quot_q <= {quot_q[NW-2:0], q_bit};
      rem_q  <= q_bit ? RW'(rem_sh - {1'b0, rate_q}) : rem_sh[RW-1:0];
      cnt_q  <= cnt_q - CNTW'(1);
    end
    if (cmd_i.commit) begin
      granted_q <= granted_d;
      avail_q   <= tbrl_pkg::TOKEN_W'(level_d[LW-1:FRACTION_BITS]);
      wait_q    <= wait_d;
      unb_q     <= unb_d;
    end
  end

  assign granted_o        = granted_q;
  assign available_o      = avail_q;
  assign wait_us_o        = wait_q;
  assign wait_unbounded_o = unb_q;

endmodule

`default_nettype wire

FILE: sv/tbrl_checker.sv
// Port-level checker for the token bucket rate limiter, bound to the top.
// Uses token_bucket_rate_limiter_top_macros.svh and tbrl_pkg widths.
`default_nettype none
`include "token_bucket_rate_limiter_top_macros.svh"

module tbrl_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic                            granted_o,
  input wire logic [tbrl_pkg::TOKEN_W-1:0]    available_o,
  input wire logic [tbrl_pkg::WAIT_W-1:0]     wait_us_o,
  input wire logic                            wait_unbounded_o
);

  // a grant comes only from take one, which never reports a wait
  `TBRL_ASSERT(a_grant_no_wait, clk_i, rst_ni, out_valid_o && granted_o |-> (wait_us_o == '0) && !wait_unbounded_o, "grant with wait fields set")

  `TBRL_ASSERT(a_unbounded_sat, clk_i, rst_ni, out_valid_o && wait_unbounded_o |-> (wait_us_o == '1), "unbounded wait not saturated")

  // one word in flight: the input closes right after an accept
  `TBRL_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "input open right after accept")

  `TBRL_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(available_o) && $stable(wait_us_o) && $stable(granted_o), "stalled result changed")

  `TBRL_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind token_bucket_rate_limiter_top tbrl_checker u_tbrl_checker (.*);

`default_nettype wire

FILE: dv/token_bucket_rate_limiter_top_tb.sv
// Self-checking testbench for token_bucket_rate_limiter_top: a directed plan, then random
// phases under random idling; each result checked against a bucket predictor or the plan.
// Depends on tbrl_pkg and the RTL of the top level only.
`default_nettype none

module token_bucket_rate_limiter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbrl_pkg::*;

  localparam int unsigned FRAC = FRACTION_BITS_DEF;
  localparam int unsigned DRAIN_CYCLES = 48;     // outlasts the longest operation, a divide
  localparam int unsigned STALL_LIMIT = 4000;    // cycles without any handshake
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned N_PHASES = 6;
  localparam int unsigned PHASE_WORDS = 84;

  // codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                granted;
    logic [TOKEN_W-1:0]  available;
    logic [WAIT_W-1:0]   wait_us;
    logic                wait_unbounded;
  } bucket_result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_data;
    logic [OP_W-1:0]      op;
    logic [TOKEN_W-1:0]   count;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 known;
    bucket_result_t       result;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [OP_W-1:0]       operation_i;
  logic [TOKEN_W-1:0]    token_count_i;
  logic [ELAPSED_W-1:0]  elapsed_us_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  granted_o;
  logic [TOKEN_W-1:0]    available_o;
  logic [WAIT_W-1:0]     wait_us_o;
  logic                  wait_unbounded_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DAT_W-1:0]  cfg_data_i;

  token_bucket_rate_limiter_top dut (.*);

  // predictor state
  logic [63:0]          level_q;
  logic [RATE_W-1:0]    rate_q;
  logic [TOKEN_W-1:0]   burst_q;

  bucket_result_t pending_results[$];
  int unsigned    mismatches;
  int unsigned    gap_pct;
  int unsigned    stall_pct;
  bit             quiet;
  bit             hold_req;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] bucket_cap();
    logic [63:0] b;
    b = (burst_q == '0) ? 64'd1 : 64'(burst_q);
    return b << FRAC;
  endfunction

  function automatic bucket_result_t bucket_apply(logic [OP_W-1:0] op,
                                                  logic [TOKEN_W-1:0] count,
                                                  logic [ELAPSED_W-1:0] elapsed);
    logic [63:0] need;
    logic [63:0] sum;
    logic [63:0] deficit;
    logic [63:0] quo;
    bucket_result_t r;
    r = '0;
    need = 64'(count) << FRAC;
    case (op)
      OP_REFILL: begin
        sum = level_q + 64'(elapsed) * 64'(rate_q);
        level_q = (sum > bucket_cap()) ? bucket_cap() : sum;
      end
      OP_TAKE: begin
        if (level_q >= (64'd1 << FRAC)) begin
          level_q = level_q - (64'd1 << FRAC);
          r.granted = 1'b1;
        end
      end
      OP_CONSUME: level_q = (need <= level_q) ? level_q - need : 64'd0;
      OP_WAIT: begin
        if (level_q < need) begin
          if (rate_q == '0) begin
            r.wait_unbounded = 1'b1;
            r.wait_us = '1;
          end else begin
            deficit = need - level_q;
            quo = (deficit + 64'(rate_q) - 64'd1) / 64'(rate_q);
            r.wait_us = (quo > 64'hFFFF_FFFF) ? '1 : quo[WAIT_W-1:0];
          end
        end
      end
      OP_RESTART: level_q = bucket_cap();
      default: ;
    endcase
    r.available = level_q[FRAC +: TOKEN_W];
    return r;
  endfunction

  function automatic plan_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic plan_row_t row_word(logic [OP_W-1:0] op, logic [TOKEN_W-1:0] count,
                                         logic [ELAPSED_W-1:0] elapsed);
    plan_row_t r;
    r = '0;
    r.op = op;
    r.count = count;
    r.elapsed = elapsed;
    return r;
  endfunction

  function automatic plan_row_t row_known(logic [OP_W-1:0] op, logic [TOKEN_W-1:0] count,
                                          logic [ELAPSED_W-1:0] elapsed, logic granted,
                                          logic [TOKEN_W-1:0] available,
                                          logic [WAIT_W-1:0] wait_us, logic unbounded);
    plan_row_t r;
    r = row_word(op, count, elapsed);
    r.known = 1'b1;
    r.result = '{granted, available, wait_us, unbounded};
    return r;
  endfunction

  // Drive one word from the next falling edge and hold it until taken.
  task automatic send_word(logic [OP_W-1:0] op, logic [TOKEN_W-1:0] count,
                           logic [ELAPSED_W-1:0] elapsed, logic known,
                           bucket_result_t typed);
    bucket_result_t predicted;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= op;
    token_count_i <= count;
    elapsed_us_i <= elapsed;
    do @(posedge clk_i); while (in_stall_o);
    predicted = bucket_apply(op, count, elapsed);
    pending_results.push_back(known ? typed : predicted);
  endtask

  task automatic idle_input(int unsigned cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Drop valid, drain every pending result, then let the divider settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_REFILL_PER_US) rate_q = data;
    else if (idx == REG_MAX_BURST) burst_q = data[TOKEN_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    bucket_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word: expected none actual available %0h",
                 $time, available_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("granted", 32'(want.granted), 32'(granted_o));
        compare_field("available", 32'(want.available), 32'(available_o));
        compare_field("wait_us", want.wait_us, wait_us_o);
        compare_field("wait_unbounded", 32'(want.wait_unbounded), 32'(wait_unbounded_o));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("[token_bucket_rate_limiter_top] ERROR");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned span;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // hold off long enough for the block to fill and stall its input
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(99) < stall_pct) begin
        span = $urandom_range(11, 1);
        out_stall_i <= 1'b1;
        repeat (span) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    logic [OP_W-1:0] op;
    logic [TOKEN_W-1:0] count;
    logic [ELAPSED_W-1:0] elapsed;
    logic [CFG_DAT_W-1:0] rate_pick;
    logic [CFG_DAT_W-1:0] burst_pick;
    int unsigned roll;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OP_REFILL;
    token_count_i = '0;
    elapsed_us_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_REFILL_PER_US;
    cfg_data_i = '0;
    mismatches = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    gap_pct = 30;
    stall_pct = 30;
    level_q = 64'd1 << FRAC;
    rate_q = '0;
    burst_q = 16'd1;

    plan = '{
      // reset state: one token, zero rate, burst of one
      row_known(OP_WAIT, 16'd1, 24'd0, 1'b0, 16'd1, 32'd0, 1'b0),
      row_known(OP_WAIT, 16'hFFFF, 24'd0, 1'b0, 16'd1, 32'hFFFF_FFFF, 1'b1),
      row_known(OP_TAKE, 16'd0, 24'd0, 1'b1, 16'd0, 32'd0, 1'b0),
      row_known(OP_TAKE, 16'd0, 24'd0, 1'b0, 16'd0, 32'd0, 1'b0),
      row_known(OP_REFILL, 16'd0, 24'hFF_FFFF, 1'b0, 16'd0, 32'd0, 1'b0),
      row_known(OP_RESTART, 16'd0, 24'd0, 1'b0, 16'd1, 32'd0, 1'b0),
      row_known(OP_CONSUME, 16'd0, 24'd0, 1'b0, 16'd1, 32'd0, 1'b0),
      row_known(OP_CONSUME, 16'hFFFF, 24'd0, 1'b0, 16'd0, 32'd0, 1'b0),
      row_known(OP_SPARE_LO, 16'hFFFF, 24'hFF_FFFF, 1'b0, 16'd0, 32'd0, 1'b0),
      row_known(OP_SPARE_MID, 16'd1, 24'd1, 1'b0, 16'd0, 32'd0, 1'b0),
      row_known(OP_SPARE_HI, 16'd0, 24'd0, 1'b0, 16'd0, 32'd0, 1'b0),
      row_cfg(REG_REFILL_PER_US, 32'h0180_0000),
      row_cfg(REG_MAX_BURST, 32'h0000_FFFF),
      row_word(OP_REFILL, 16'd0, 24'd100),
      row_word(OP_WAIT, 16'hFFFF, 24'd0),
      row_known(OP_REFILL, 16'd0, 24'hFF_FFFF, 1'b0, 16'hFFFF, 32'd0, 1'b0),
      row_word(OP_TAKE, 16'd0, 24'd0),
      row_word(OP_CONSUME, 16'd1000, 24'd0),
      row_word(OP_WAIT, 16'd0, 24'd0),
      // lowered burst keeps the level until the next refill
      row_cfg(REG_MAX_BURST, 32'd10),
      row_word(OP_TAKE, 16'd0, 24'd0),
      row_known(OP_REFILL, 16'd0, 24'd0, 1'b0, 16'd10, 32'd0, 1'b0),
      row_cfg(REG_MAX_BURST, 32'd0),
      row_known(OP_RESTART, 16'd0, 24'd0, 1'b0, 16'd1, 32'd0, 1'b0),
      row_cfg(REG_REFILL_PER_US, 32'hFFFF_FFFF),
      row_cfg(REG_MAX_BURST, 32'hABCD_0005),
      row_known(OP_CONSUME, 16'hFFFF, 24'd0, 1'b0, 16'd0, 32'd0, 1'b0),
      row_word(OP_WAIT, 16'hFFFF, 24'd0),
      row_cfg(REG_REFILL_PER_US, 32'd1),
      row_known(OP_WAIT, 16'hFFFF, 24'd0, 1'b0, 16'd0, 32'hFFFF_FFFF, 1'b0),
      row_word(OP_REFILL, 16'd0, 24'hFF_FFFF),
      row_word(OP_WAIT, 16'd1, 24'd0)
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        if ($urandom_range(99) < gap_pct) idle_input($urandom_range(11, 1));
        send_word(plan[i].op, plan[i].count, plan[i].elapsed, plan[i].known,
                  plan[i].result);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case ($urandom_range(4))
        0: rate_pick = '0;
        1: rate_pick = 32'd1;
        2: rate_pick = '1;
        3: rate_pick = $urandom;
        default: rate_pick = $urandom_range(32'h0400_0000, 32'h0010_0000);
      endcase
      case ($urandom_range(4))
        0: burst_pick = '0;
        1: burst_pick = 32'h0000_FFFF;
        2: burst_pick = $urandom;
        default: burst_pick = $urandom_range(40, 1);
      endcase
      // first phase gets a rate that makes refills and waits meaningful
      if (ph == 0) rate_pick = 32'h0080_0000;
      write_reg(REG_REFILL_PER_US, rate_pick);
      write_reg(REG_MAX_BURST, burst_pick);

      quiet = (ph == N_PHASES - 1);
      gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 5);
      stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 5);
      if (ph == 1) hold_req = 1'b1;

      for (int k = 0; k < PHASE_WORDS; k++) begin
        roll = $urandom_range(99);
        if (roll < 25) op = OP_REFILL;
        else if (roll < 45) op = OP_TAKE;
        else if (roll < 60) op = OP_CONSUME;
        else if (roll < 85) op = OP_WAIT;
        else if (roll < 93) op = OP_RESTART;
        else op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        count = TOKEN_W'(($urandom_range(3) == 0) ? $urandom
                                                  : $urandom_range(32'(burst_q) + 2));
        elapsed = ELAPSED_W'(($urandom_range(7) == 0) ? $urandom : $urandom_range(64));
        if (!quiet && $urandom_range(99) < gap_pct) idle_input($urandom_range(11, 1));
        send_word(op, count, elapsed, 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[token_bucket_rate_limiter_top] OK");
    end else begin
      $display("[token_bucket_rate_limiter_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
